// ----- design/brs_pkg.sv -----
// Shared types, constants and helper functions for the bounded random integer sampler.
// Used by brs_lane, brs_merge and bounded_random_integer_sampler; depends on nothing.
package brs_pkg;

   // Field widths that are fixed by the item format.
   localparam int DATA_W    = 64;
   localparam int TRY_W     = 8;
   localparam int POS_COUNT = 64;
   localparam int POS_IDX_W = 6;
   localparam int BLOCK_W   = 7;
   localparam int REM_W     = 6;

   // Configuration port layout.
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic REG_MAX_TRIES = 1'b0;
   localparam logic [TRY_W-1:0] MAX_TRIES_RESET = 8'd16;

   // One input item.
   typedef struct packed {
      logic [DATA_W-1:0] lower;
      logic [DATA_W-1:0] upper;
      logic [DATA_W-1:0] random_word;
   } req_item_type;

   // One result item.
   typedef struct packed {
      logic [DATA_W-1:0] value;
      logic              fell_back;
   } rsp_item_type;

   // What one lane reports about its chunk.
   typedef struct packed {
      logic              hit;
      logic [DATA_W-1:0] chunk;
   } lane_result_type;

   // Index of the highest set bit, found by halving the search window six times.
   function automatic logic [POS_IDX_W-1:0] msb_index(input logic [DATA_W-1:0] v);
      logic [DATA_W-1:0]    x;
      logic [POS_IDX_W-1:0] n;
      x = v;
      n = '0;
      if (x[63:32] != '0) begin
         n[5] = 1'b1;
         x = x >> 32;
      end
      if (x[31:16] != '0) begin
         n[4] = 1'b1;
         x = x >> 16;
      end
      if (x[15:8] != '0) begin
         n[3] = 1'b1;
         x = x >> 8;
      end
      if (x[7:4] != '0) begin
         n[2] = 1'b1;
         x = x >> 4;
      end
      if (x[3:2] != '0) begin
         n[1] = 1'b1;
         x = x >> 2;
      end
      if (x[1]) begin
         n[0] = 1'b1;
      end
      return n;
   endfunction

endpackage

// ----- design/brs_lane.sv -----
// One chunk lane: extracts a chunk of the shifted random word and tests it against the span.
// Depends on brs_pkg for the lane result type.
module brs_lane #(
   parameter int SHIFT_W = 10
) (
   input  logic [brs_pkg::DATA_W-1:0] src,
   input  logic [SHIFT_W-1:0]         shift,
   input  logic [brs_pkg::DATA_W-1:0] mask,
   input  logic [brs_pkg::DATA_W-1:0] span,
   input  logic                       active,
   output brs_pkg::lane_result_type   result
);
   import brs_pkg::*;

   logic [DATA_W-1:0] chunk;

   // A shift of a whole word or more leaves an empty chunk.
   assign chunk = (src >> shift) & mask;

   // The chunk qualifies when it lies inside the span and exists for this span size.
   assign result.chunk = chunk;
   assign result.hit   = active && (chunk <= span);

endmodule

// ----- design/brs_merge.sv -----
// Merging stage: picks the lowest-numbered lane whose chunk qualified.
// Depends on brs_pkg for the lane result type.
module brs_merge #(
   parameter int LANE_COUNT = 8
) (
   input  brs_pkg::lane_result_type lanes [LANE_COUNT],
   output brs_pkg::lane_result_type merged
);
   import brs_pkg::*;

   // Scan from the top so the lowest qualifying lane is the one left standing.
   always_comb begin
      merged = '0;
      for (int j = LANE_COUNT - 1; j >= 0; j--) begin
         if (lanes[j].hit) begin
            merged = lanes[j];
         end
      end
   end

endmodule

// ----- design/bounded_random_integer_sampler.sv -----
// Bounded random integer sampler. An empty range skips the scan and goes from the size step
// straight to the output. Otherwise the span, size and load setup states, then the scan over
// lane groups (one lane group per cycle), an add state on a hit and the output state.
// One item is in work at a time: the next is accepted after the current one leaves the core.
// Synchronous active-high reset sets max_tries to 16, clears the try count and empties output.
module bounded_random_integer_sampler #(
   parameter int WORD_BITS  = 64,
   parameter int LANE_COUNT = 8
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  brs_pkg::req_item_type               req_item,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output brs_pkg::rsp_item_type               rsp_item,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [brs_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  logic [brs_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic [brs_pkg::CSR_DATA_W-1:0]      csr_prdata,
   output logic                                csr_pready
);
   import brs_pkg::*;

   localparam int OFF_W = $clog2(LANE_COUNT * POS_COUNT + 1);
   localparam int CNT_W = $clog2(POS_COUNT + LANE_COUNT + 1);
   localparam logic [DATA_W-1:0] ONES      = {DATA_W{1'b1}};
   localparam logic [DATA_W-1:0] WORD_MASK = ONES >> (DATA_W - WORD_BITS);

   typedef enum logic [6:0] {
      ST_IDLE = 7'b0000001,
      ST_SPAN = 7'b0000010,
      ST_SIZE = 7'b0000100,
      ST_LOAD = 7'b0001000,
      ST_SCAN = 7'b0010000,
      ST_ADD  = 7'b0100000,
      ST_EMIT = 7'b1000000
   } state_type;

   state_type              state_ff, state_in;
   logic [DATA_W-1:0]      lower_ff, lower_in;
   logic [DATA_W-1:0]      upper_ff, upper_in;
   logic [DATA_W-1:0]      word_ff, word_in;
   logic [DATA_W-1:0]      span_ff, span_in;
   logic                   empty_ff, empty_in;
   logic [POS_IDX_W-1:0]   pos_idx_ff, pos_idx_in;
   logic [DATA_W-1:0]      mid_ff, mid_in;
   logic [DATA_W-1:0]      mask_ff, mask_in;
   logic [BLOCK_W-1:0]     blocks_ff, blocks_in;
   logic [DATA_W-1:0]      sh_ff, sh_in;
   logic [OFF_W-1:0]       step_ff, step_in;
   logic [OFF_W-1:0]       off_ff [LANE_COUNT];
   logic [OFF_W-1:0]       off_in [LANE_COUNT];
   logic [CNT_W-1:0]       base_ff, base_in;
   logic [DATA_W-1:0]      res_ff, res_in;
   logic [DATA_W-1:0]      fin_value_ff, fin_value_in;
   logic                   fin_fb_ff, fin_fb_in;
   logic [TRY_W-1:0]       tries_ff, tries_in;
   logic [TRY_W-1:0]       max_tries_ff, max_tries_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_item_type           rsp_item_ff, rsp_item_in;

   logic [BLOCK_W-1:0]     blocks_tab [POS_COUNT];
   logic [REM_W-1:0]       rem_tab [POS_COUNT];
   logic                   lane_active [LANE_COUNT];
   lane_result_type        lane_res [LANE_COUNT];
   lane_result_type        merged;

   logic                   out_free;
   logic                   csr_write;
   logic [POS_IDX_W:0]     pos_w;
   logic [TRY_W:0]         limit;
   logic [TRY_W:0]         tries_next;
   logic                   last_group;

   // Chunk count and pre-shift for every possible span bit length, fixed at elaboration.
   for (genvar p = 0; p < POS_COUNT; p++) begin : g_tab
      localparam int Blocks  = WORD_BITS / (p + 1);
      localparam int Divisor = (Blocks != 0) ? Blocks : 1;
      localparam int Rem     = (Blocks != 0) ? (WORD_BITS % Divisor) : 0;
      assign blocks_tab[p] = BLOCK_W'(Blocks);
      assign rem_tab[p]    = REM_W'(Rem);
   end

   // Lanes: lane j tests chunk number base + j of the current group.
   for (genvar j = 0; j < LANE_COUNT; j++) begin : g_lane
      assign lane_active[j] = (base_ff + CNT_W'(j)) < CNT_W'(blocks_ff);
      brs_lane #(
         .SHIFT_W(OFF_W)
      ) u_lane (
         .src   (sh_ff),
         .shift (off_ff[j]),
         .mask  (mask_ff),
         .span  (span_ff),
         .active(lane_active[j]),
         .result(lane_res[j])
      );
   end

   brs_merge #(
      .LANE_COUNT(LANE_COUNT)
   ) u_merge (
      .lanes (lane_res),
      .merged(merged)
   );

   // Handshake and configuration port outputs.
   assign req_stall  = (state_ff != ST_IDLE);
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_item   = rsp_item_ff;
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[CSR_ADDR_W-1] == REG_MAX_TRIES)
                       ? CSR_DATA_W'(max_tries_ff) : '0;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite
                       && (csr_paddr[CSR_ADDR_W-1] == REG_MAX_TRIES);

   // Helper values for the sequencer.
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign pos_w      = {1'b0, pos_idx_ff} + (POS_IDX_W + 1)'(1);
   assign limit      = (max_tries_ff == '0) ? (TRY_W + 1)'(1) : {1'b0, max_tries_ff};
   assign tries_next = {1'b0, tries_ff} + (TRY_W + 1)'(1);
   assign last_group = (base_ff + CNT_W'(LANE_COUNT)) >= CNT_W'(blocks_ff);

   // Sequencer: next values of all registers.
   always_comb begin
      state_in     = state_ff;
      lower_in     = lower_ff;
      upper_in     = upper_ff;
      word_in      = word_ff;
      span_in      = span_ff;
      empty_in     = empty_ff;
      pos_idx_in   = pos_idx_ff;
      mid_in       = mid_ff;
      mask_in      = mask_ff;
      blocks_in    = blocks_ff;
      sh_in        = sh_ff;
      step_in      = step_ff;
      off_in       = off_ff;
      base_in      = base_ff;
      res_in       = res_ff;
      fin_value_in = fin_value_ff;
      fin_fb_in    = fin_fb_ff;
      tries_in     = tries_ff;
      max_tries_in = max_tries_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_item_in  = rsp_item_ff;

      if (csr_write) begin
         max_tries_in = csr_pwdata[TRY_W-1:0];
      end

      // A waiting result leaves when the consumer takes it.
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               lower_in = req_item.lower;
               upper_in = req_item.upper;
               word_in  = req_item.random_word & WORD_MASK;
               state_in = ST_SPAN;
            end
         end
         ST_SPAN: begin
            span_in  = upper_ff - lower_ff;
            empty_in = (upper_ff <= lower_ff);
            state_in = ST_SIZE;
         end
         ST_SIZE: begin
            // Index of the span's highest set bit, and the midpoint taken without losing the carry.
            pos_idx_in = msb_index(span_ff);
            mid_in     = (lower_ff >> 1) + (upper_ff >> 1)
                         + DATA_W'(lower_ff[0] & upper_ff[0]);
            if (empty_ff) begin
               fin_value_in = lower_ff;
               fin_fb_in    = 1'b0;
               state_in     = ST_EMIT;
            end else begin
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            mask_in   = ONES >> (POS_IDX_W'(POS_COUNT - 1) - pos_idx_ff);
            blocks_in = blocks_tab[pos_idx_ff];
            sh_in     = word_ff >> rem_tab[pos_idx_ff];
            step_in   = OFF_W'(OFF_W'(LANE_COUNT) * OFF_W'(pos_w));
            for (int j = 0; j < LANE_COUNT; j++) begin
               off_in[j] = OFF_W'(OFF_W'(j) * OFF_W'(pos_w));
            end
            base_in  = '0;
            state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (merged.hit) begin
               res_in   = merged.chunk;
               state_in = ST_ADD;
            end else if (last_group) begin
               // The whole word was rejected: fall back or count the try.
               if (tries_next >= limit) begin
                  fin_value_in = mid_ff;
                  fin_fb_in    = 1'b1;
                  state_in     = ST_EMIT;
               end else begin
                  tries_in = tries_next[TRY_W-1:0];
                  state_in = ST_IDLE;
               end
            end else begin
               sh_in   = sh_ff >> step_ff;
               base_in = base_ff + CNT_W'(LANE_COUNT);
            end
         end
         ST_ADD: begin
            fin_value_in = lower_ff + res_ff;
            fin_fb_in    = 1'b0;
            state_in     = ST_EMIT;
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in          = 1'b1;
               rsp_item_in.value     = fin_value_ff;
               rsp_item_in.fell_back = fin_fb_ff;
               tries_in              = '0;
               state_in              = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         tries_ff     <= '0;
         max_tries_ff <= MAX_TRIES_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         tries_ff     <= tries_in;
         max_tries_ff <= max_tries_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      lower_ff     <= lower_in;
      upper_ff     <= upper_in;
      word_ff      <= word_in;
      span_ff      <= span_in;
      empty_ff     <= empty_in;
      pos_idx_ff   <= pos_idx_in;
      mid_ff       <= mid_in;
      mask_ff      <= mask_in;
      blocks_ff    <= blocks_in;
      sh_ff        <= sh_in;
      step_ff      <= step_in;
      off_ff       <= off_in;
      base_ff      <= base_in;
      res_ff       <= res_in;
      fin_value_ff <= fin_value_in;
      fin_fb_ff    <= fin_fb_in;
      rsp_item_ff  <= rsp_item_in;
   end

endmodule
